// ----- hdl/shdf_pkg.sv -----
// shared types and constants for the sync header frame deframer
package shdf_pkg;

   localparam logic [7:0] SYNC_0   = 8'h55;
   localparam logic [7:0] SYNC_1   = 8'h4E;
   localparam logic [7:0] SYNC_2   = 8'h45;
   localparam logic [7:0] SYNC_3   = 8'h52;
   localparam logic [7:0] RESERVED = 8'h00;
   localparam logic [7:0] COLON    = 8'h3A;

   // xor of the fixed header bytes, length byte folded in separately
   localparam logic [7:0] HDR_XOR = SYNC_0 ^ SYNC_1 ^ SYNC_2 ^ SYNC_3 ^ RESERVED ^ COLON;

   typedef enum logic [2:0] {
      PH_SYNC0 = 3'd0,
      PH_SYNC1 = 3'd1,
      PH_SYNC2 = 3'd2,
      PH_SYNC3 = 3'd3,
      PH_LEN   = 3'd4,
      PH_RSV   = 3'd5,
      PH_COLON = 3'd6,
      PH_BODY  = 3'd7
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_of_frame;
      logic       checksum_ok;
   } result_type;

endpackage

// ----- hdl/shdf_parser.sv -----
// header parser, length counter and running xor, one byte per cycle while byte_take is high
module shdf_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                byte_take,
   input  logic [7:0]          rx_byte,
   output logic                res_push,
   output shdf_pkg::result_type res_item
);
   import shdf_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [7:0] bytes_left_ff, bytes_left_in;
   logic [7:0] running_xor_ff, running_xor_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_SYNC0;
         bytes_left_ff  <= 8'd0;
         running_xor_ff <= 8'd0;
      end else if (byte_take) begin
         phase_ff       <= phase_in;
         bytes_left_ff  <= bytes_left_in;
         running_xor_ff <= running_xor_in;
      end
   end

   always_comb begin
      phase_in       = PH_SYNC0;
      bytes_left_in  = bytes_left_ff;
      running_xor_in = running_xor_ff;
      res_push       = 1'b0;
      res_item       = '{data_byte: rx_byte, last_of_frame: 1'b0, checksum_ok: 1'b0};
      unique case (phase_ff)
         PH_SYNC0: phase_in = (rx_byte == SYNC_0) ? PH_SYNC1 : PH_SYNC0;
         PH_SYNC1: phase_in = (rx_byte == SYNC_1) ? PH_SYNC2 : PH_SYNC0;
         PH_SYNC2: phase_in = (rx_byte == SYNC_2) ? PH_SYNC3 : PH_SYNC0;
         PH_SYNC3: phase_in = (rx_byte == SYNC_3) ? PH_LEN   : PH_SYNC0;
         PH_LEN: begin
            bytes_left_in = rx_byte;
            // zero length aborts the frame
            phase_in = (rx_byte == 8'd0) ? PH_SYNC0 : PH_RSV;
         end
         PH_RSV: phase_in = (rx_byte == RESERVED) ? PH_COLON : PH_SYNC0;
         PH_COLON: begin
            if (rx_byte == COLON) begin
               running_xor_in = HDR_XOR ^ bytes_left_ff;
               phase_in       = PH_BODY;
            end
         end
         PH_BODY: begin
            res_push = byte_take;
            if (bytes_left_ff > 8'd1) begin
               running_xor_in = running_xor_ff ^ rx_byte;
               bytes_left_in  = bytes_left_ff - 8'd1;
               phase_in       = PH_BODY;
            end else begin
               // checksum byte closes the frame
               bytes_left_in          = 8'd0;
               res_item.last_of_frame = 1'b1;
               res_item.checksum_ok   = (running_xor_ff == rx_byte);
            end
         end
         default: phase_in = PH_SYNC0;
      endcase
   end

endmodule

// ----- hdl/shdf_out_buf.sv -----
// result register with a skid entry so the input stall is registered
module shdf_out_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  shdf_pkg::result_type push_item,
   output logic                 full,
   output logic                 out_valid,
   input  logic                 out_stall,
   output shdf_pkg::result_type out_item
);
   import shdf_pkg::*;

   logic       out_valid_ff;
   logic       skid_valid_ff;
   result_type out_item_ff;
   result_type skid_item_ff;
   logic       pop;

   assign pop       = out_valid_ff & ~out_stall;
   assign full      = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_item  = out_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         priority if (skid_valid_ff) begin
            if (pop) begin
               skid_valid_ff <= 1'b0;
            end
         end else if (push && out_valid_ff && !pop) begin
            skid_valid_ff <= 1'b1;
         end else if (push) begin
            out_valid_ff <= 1'b1;
         end else if (pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      priority if (skid_valid_ff) begin
         if (pop) begin
            out_item_ff <= skid_item_ff;
         end
      end else if (push && out_valid_ff && !pop) begin
         skid_item_ff <= push_item;
      end else if (push) begin
         out_item_ff <= push_item;
      end
   end

endmodule

// ----- hdl/sync_header_frame_deframer.sv -----
// top level of the sync header frame deframer
//
// bytes from a serial link enter on req_ (req_valid, req_stall, req_rx_byte).
// the block hunts for the four-byte sync word, then checks the length,
// reserved and colon bytes; any mismatch consumes the byte and restarts the hunt.
// every body byte comes out on rsp_ with rsp_data_byte; the final body byte is
// the checksum and comes out with rsp_last_of_frame high and rsp_checksum_ok
// telling whether it matched the xor over header and payload.
// header bytes and aborted frames give no output item.
// one byte is taken every cycle while req_stall is low; a body byte that is taken
// is registered in the result register after the parser, or in the skid entry if that is held.
// a skid entry behind the result register lets one more item in while the
// receiver stalls; req_stall then rises (registered) until the receiver takes
// an item, so no item is lost.
// synchronous reset returns the parser to the hunt for the first sync byte and
// empties the result register and the skid entry; no clearing pass is needed.
module sync_header_frame_deframer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_last_of_frame,
   output logic       rsp_checksum_ok
);
   import shdf_pkg::*;

   logic       byte_take;
   logic       res_push;
   result_type res_item;
   result_type out_item;

   assign byte_take = req_valid & ~req_stall;

   shdf_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .byte_take (byte_take),
      .rx_byte   (req_rx_byte),
      .res_push  (res_push),
      .res_item  (res_item)
   );

   shdf_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_item (res_item),
      .full      (req_stall),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_item  (out_item)
   );

   assign rsp_data_byte     = out_item.data_byte;
   assign rsp_last_of_frame = out_item.last_of_frame;
   assign rsp_checksum_ok   = out_item.checksum_ok;

   a_ok_only_when_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_checksum_ok |-> rsp_last_of_frame)
      else $error("checksum_ok set on a payload item");

   a_stall_needs_pending: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no pending result");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("output not empty after reset");

   a_push_needs_room: assert property (@(posedge clock) disable iff (reset)
      res_push |-> !req_stall)
      else $error("result pushed while buffer full");

endmodule

// ----- sim/sync_header_frame_deframer_tb.sv -----
// self-checking testbench for the sync header frame deframer
module sync_header_frame_deframer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import shdf_pkg::*;

   localparam int TARGET_BYTES = 1950;
   localparam int HOLD_LEN     = 80;
   localparam int IDLE_LIMIT   = 1000;
   localparam int MAX_REPORTS  = 10;

   // frame parser mirror plus the queue of items it predicts
   class frame_scoreboard;
      result_type frame_out_q[$];
      phase_type  phase;
      logic [7:0] bytes_left;
      logic [7:0] running_xor;
      int         errors;
      int         checked;
      int         sums_good;
      int         sums_bad;

      function new();
         phase = PH_SYNC0;
         bytes_left = 8'd0;
         running_xor = 8'd0;
         errors = 0;
         checked = 0;
         sums_good = 0;
         sums_bad = 0;
      endfunction

      function int pending();
         return frame_out_q.size();
      endfunction

      function logic [7:0] sync_at(phase_type ph);
         case (ph)
            PH_SYNC0: return SYNC_0;
            PH_SYNC1: return SYNC_1;
            PH_SYNC2: return SYNC_2;
            default:  return SYNC_3;
         endcase
      endfunction

      function void note_byte(logic [7:0] b);
         result_type r;
         case (phase)
            PH_SYNC0, PH_SYNC1, PH_SYNC2, PH_SYNC3: begin
               // a wrong byte is dropped, not retried as a first sync byte
               phase = (b == sync_at(phase)) ? phase_type'(phase + 3'd1) : PH_SYNC0;
            end
            PH_LEN: begin
               bytes_left = b;
               phase = (b == 8'd0) ? PH_SYNC0 : PH_RSV;
            end
            PH_RSV: begin
               phase = (b == RESERVED) ? PH_COLON : PH_SYNC0;
            end
            PH_COLON: begin
               if (b == COLON) begin
                  running_xor = HDR_XOR ^ bytes_left;
                  phase = PH_BODY;
               end else begin
                  phase = PH_SYNC0;
               end
            end
            default: begin
               r.data_byte = b;
               if (bytes_left > 8'd1) begin
                  running_xor = running_xor ^ b;
                  bytes_left = bytes_left - 8'd1;
                  r.last_of_frame = 1'b0;
                  r.checksum_ok = 1'b0;
               end else begin
                  bytes_left = 8'd0;
                  phase = PH_SYNC0;
                  r.last_of_frame = 1'b1;
                  r.checksum_ok = (running_xor == b);
               end
               frame_out_q.push_back(r);
            end
         endcase
      endfunction

      function void check_result(logic [7:0] data, logic last, logic ok);
         result_type want;
         if (frame_out_q.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%t unexpected item: data=%h last=%b ok=%b", $realtime, data, last, ok);
            return;
         end
         want = frame_out_q.pop_front();
         checked++;
         if (want.last_of_frame) begin
            if (want.checksum_ok) sums_good++;
            else sums_bad++;
         end
         if (data !== want.data_byte || last !== want.last_of_frame ||
             ok !== want.checksum_ok) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%t mismatch: expected data=%h last=%b ok=%b, got data=%h last=%b ok=%b",
                        $realtime, want.data_byte, want.last_of_frame, want.checksum_ok,
                        data, last, ok);
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_byte = 8'd0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_data_byte;
   logic       rsp_last_of_frame;
   logic       rsp_checksum_ok;

   frame_scoreboard sb = new();

   logic [7:0] tx_q[$];
   int         burst_left = 0;
   bit         steady = 1'b0;
   int         bytes_sent = 0;
   int         counted_bytes = 0;
   int         hold_reqs = 0;
   int         holds_done = 0;
   int         idle_cycles = 0;

   sync_header_frame_deframer dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data_byte(rsp_data_byte),
      .rsp_last_of_frame(rsp_last_of_frame),
      .rsp_checksum_ok(rsp_checksum_ok)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_byte(req_rx_byte);
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_data_byte, rsp_last_of_frame, rsp_checksum_ok);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%t no handshake for %0d cycles", $realtime, IDLE_LIMIT);
            $display("[sync_header_frame_deframer] ERROR");
            $finish;
         end
      end
   end

   // receiver: stall pattern picked at random for each span, long holds on request
   initial begin
      int mode;
      int span;
      int k;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(40, 200);
         for (k = 0; k < span; k++) begin
            @(posedge clock);
            if (hold_reqs != holds_done) begin
               rsp_stall <= 1'b1;
               repeat (HOLD_LEN) @(posedge clock);
               holds_done++;
               rsp_stall <= 1'b0;
            end else begin
               case (mode)
                  0: rsp_stall <= 1'b0;
                  1: rsp_stall <= ($urandom_range(0, 2) == 0);
                  2: rsp_stall <= ((k % 5) < 2);
                  default: rsp_stall <= ($urandom_range(0, 3) != 0);
               endcase
            end
         end
      end
   end

   task automatic send_byte(input logic [7:0] b);
      if (burst_left == 0) begin
         if (!steady && $urandom_range(0, 2) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic flush_tx(input bit counted);
      while (tx_q.size() != 0) begin
         send_byte(tx_q.pop_front());
         if (counted) counted_bytes++;
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic push_header(input logic [7:0] len);
      tx_q.push_back(SYNC_0);
      tx_q.push_back(SYNC_1);
      tx_q.push_back(SYNC_2);
      tx_q.push_back(SYNC_3);
      tx_q.push_back(len);
      tx_q.push_back(RESERVED);
      tx_q.push_back(COLON);
   endtask

   task automatic random_frame();
      logic [7:0] hdr[7];
      logic [7:0] x;
      logic [7:0] b;
      int         kind;
      int         len;
      int         cut;
      int         i;
      kind = $urandom_range(0, 99);
      if ($urandom_range(0, 49) == 0) len = $urandom_range(200, 255);
      else if ($urandom_range(0, 4) == 0) len = $urandom_range(1, 2);
      else len = $urandom_range(1, 16);
      hdr = '{SYNC_0, SYNC_1, SYNC_2, SYNC_3, 8'(len), RESERVED, COLON};
      if (kind < 8) begin
         // zero length aborts right after the length byte
         for (i = 0; i < 4; i++) tx_q.push_back(hdr[i]);
         tx_q.push_back(8'd0);
         flush_tx(1'b1);
      end else if (kind < 20) begin
         // broken header: a wrong sync, reserved or colon byte
         cut = $urandom_range(0, 5);
         if (cut >= 4) cut++;
         for (i = 0; i < cut; i++) tx_q.push_back(hdr[i]);
         do b = 8'($urandom_range(0, 255)); while (b == hdr[cut]);
         if (cut > 0 && $urandom_range(0, 2) == 0 && hdr[cut] != SYNC_0) b = SYNC_0;
         tx_q.push_back(b);
         flush_tx(1'b1);
      end else if (kind < 28) begin
         // line noise between frames
         repeat ($urandom_range(1, 8))
            tx_q.push_back(($urandom_range(0, 3) == 0) ? SYNC_0 : 8'($urandom_range(0, 255)));
         flush_tx(1'b0);
      end else begin
         push_header(8'(len));
         x = HDR_XOR ^ 8'(len);
         for (i = 1; i < len; i++) begin
            case ($urandom_range(0, 9))
               0: b = 8'h00;
               1: b = 8'hFF;
               2: b = SYNC_0;
               default: b = 8'($urandom_range(0, 255));
            endcase
            x = x ^ b;
            tx_q.push_back(b);
         end
         if ($urandom_range(0, 9) < 3) x = x ^ 8'($urandom_range(1, 255));
         tx_q.push_back(x);
         flush_tx(1'b1);
      end
   endtask

   initial begin
      bit drained_mid;
      bit held_mid;
      drained_mid = 1'b0;
      held_mid = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // one-byte body carrying a good checksum
      push_header(8'd1);
      tx_q.push_back(HDR_XOR ^ 8'd1);
      // repeated first sync byte is dropped, so the rest does not sync
      tx_q.push_back(SYNC_0);
      tx_q.push_back(SYNC_0);
      tx_q.push_back(SYNC_1);
      tx_q.push_back(SYNC_2);
      tx_q.push_back(SYNC_3);
      // zero length
      tx_q.push_back(SYNC_0);
      tx_q.push_back(SYNC_1);
      tx_q.push_back(SYNC_2);
      tx_q.push_back(SYNC_3);
      tx_q.push_back(8'd0);
      // payload extremes with a bad checksum
      push_header(8'd3);
      tx_q.push_back(8'hFF);
      tx_q.push_back(8'h00);
      tx_q.push_back(HDR_XOR ^ 8'd3 ^ 8'hFF ^ 8'h80);
      flush_tx(1'b1);
      drain_results();

      hold_reqs++;
      while (counted_bytes < TARGET_BYTES) begin
         steady = ($urandom_range(0, 3) == 0);
         random_frame();
         if (!held_mid && counted_bytes > 1300) begin
            held_mid = 1'b1;
            hold_reqs++;
         end
         if (!drained_mid && counted_bytes > 900) begin
            drained_mid = 1'b1;
            drain_results();
         end
      end
      drain_results();
      repeat (8) @(posedge clock);

      $display("sent %0d bytes; checked %0d output items", bytes_sent, sb.checked);
      $display("frames ended: %0d with matching checksum, %0d with bad checksum",
               sb.sums_good, sb.sums_bad);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("[sync_header_frame_deframer] OK");
      end else begin
         $display("%0d mismatches, %0d items still expected", sb.errors, sb.pending());
         $display("[sync_header_frame_deframer] ERROR");
      end
      $finish;
   end

endmodule
